### rtl/plt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the piecewise-linear breakpoint table.
// No dependencies; used by the cells and the top level.
package plt_pkg;

  // Fixed result field widths
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;
  // Wide enough for any table depth in the supported range
  localparam int AT_W      = 10;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_EVAL   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_WRITE = 2'd1,
    CELL_INS   = 2'd2,
    CELL_DEL   = 2'd3
  } cell_op_e;

  // Broadcast control for the cell chain
  typedef struct packed {
    cell_op_e         op;
    logic [AT_W-1:0]  at;
  } cell_ctl_t;

endpackage

### rtl/plt_cmd_if.sv
`timescale 1ns / 1ps
// Command channel: one beat carries a command, a position and a level.
// No dependencies.
interface plt_cmd_if #(
  parameter int POS_WIDTH   = 16,
  parameter int LEVEL_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic signed [POS_WIDTH-1:0]   pos_in;
  logic signed [LEVEL_WIDTH-1:0] level_in;

  modport source (output valid, cmd, pos_in, level_in, input ready);
  modport sink   (input valid, cmd, pos_in, level_in, output ready);
endinterface

### rtl/plt_res_if.sv
`timescale 1ns / 1ps
// Result channel: one beat per command.
// Field widths of index, status and count are fixed.
interface plt_res_if #(
  parameter int LEVEL_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [LEVEL_WIDTH-1:0] result_level;
  logic [5:0]                    pt_idx;
  logic [1:0]                    status;
  logic [6:0]                    count_out;

  modport source (output valid, result_level, pt_idx, status, count_out, input ready);
  modport sink   (input valid, result_level, pt_idx, status, count_out, output ready);
endinterface

### rtl/plt_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel for the clamp mode register.
// No dependencies.
interface plt_cfg_if;
  logic valid;
  logic ready;
  logic clamp_mode;

  modport source (output valid, clamp_mode, input ready);
  modport sink   (input valid, clamp_mode, output ready);
endinterface

### rtl/plt_cell.sv
`timescale 1ns / 1ps
// One breakpoint cell of the table chain: holds a position and a level and
// takes its neighbor's entry on insert or remove. Depends on plt_pkg.
module plt_cell import plt_pkg::*; #(
  parameter int IDX = 0,
  parameter int PW  = 16,
  parameter int LW  = 16
) (
  input  logic                 clk_i,
  input  cell_ctl_t            ctl_i,
  input  logic signed [PW-1:0] new_pos_i,
  input  logic signed [LW-1:0] new_lvl_i,
  input  logic signed [PW-1:0] left_pos_i,
  input  logic signed [LW-1:0] left_lvl_i,
  input  logic signed [PW-1:0] right_pos_i,
  input  logic signed [LW-1:0] right_lvl_i,
  output logic signed [PW-1:0] pos_o,
  output logic signed [LW-1:0] lvl_o
);

  localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

  logic signed [PW-1:0] pos_q, pos_d;
  logic signed [LW-1:0] lvl_q, lvl_d;
  logic                 at_me, above;

  assign at_me = (ctl_i.at == MY_IDX);
  assign above = (MY_IDX > ctl_i.at);

  // Select new entry, neighbor entry or hold
  always_comb begin
    pos_d = pos_q;
    lvl_d = lvl_q;
    case (ctl_i.op)
      CELL_WRITE: begin
        if (at_me) begin
          lvl_d = new_lvl_i;
        end
      end
      CELL_INS: begin
        if (at_me) begin
          pos_d = new_pos_i;
          lvl_d = new_lvl_i;
        end else if (above) begin
          pos_d = left_pos_i;
          lvl_d = left_lvl_i;
        end
      end
      CELL_DEL: begin
        if (at_me || above) begin
          pos_d = right_pos_i;
          lvl_d = right_lvl_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    lvl_q <= lvl_d;
  end

  assign pos_o = pos_q;
  assign lvl_o = lvl_q;

endmodule

### rtl/plt_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on nothing; quotient valid with the done pulse.
module plt_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [NW-1:0] quot_o,
  output logic          done_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   div_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = (trial >= {1'b0, div_q});

  // One shift-subtract step per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        quo_q <= {quo_q[NW-2:0], fits};
        rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

### rtl/piecewise_linear_table.sv
`timescale 1ns / 1ps
// Top level of the piecewise-linear breakpoint table: sequencer, cell chain,
// divider. Depends on plt_pkg, plt_cmd_if, plt_res_if, plt_cfg_if, plt_cell, plt_div.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    cmd, pos_in, level_in
//   res_o    out  valid/ready    result_level, pt_idx, status, count_out
//   cfg_i    in   valid/ready    clamp_mode (ready always high)
//
// Clear goes straight from the accepted beat to the done step. Insert, remove
// and evaluate scan the chain one entry per cycle up to entry k, where the scan
// stops (k up to MAX_POINTS), then pass through the decide and done steps.
// Interpolation adds a multiply step and the serial divider.
// Reset empties the table and sets clamp mode; entry contents are not cleared.
// One beat is in flight at a time; a stalled result holds the sequencer.
module piecewise_linear_table import plt_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int POS_WIDTH   = 16,
  parameter int LEVEL_WIDTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  plt_cmd_if.sink   in_i,
  plt_res_if.source res_o,
  plt_cfg_if.sink   cfg_i
);

  localparam int PW = POS_WIDTH;
  localparam int LW = LEVEL_WIDTH;
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = PW + LW;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_POINTS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_MUL, S_DIVGO, S_DIV, S_DONE
  } state_e;

  state_e               state_q;
  cmd_e                 cmd_q;
  logic signed [PW-1:0] x_q;
  logic signed [LW-1:0] v_q;
  logic [CW-1:0]        count_q, k_q;
  logic signed [PW-1:0] cur_pos_q, prev_pos_q;
  logic signed [LW-1:0] cur_lvl_q, prev_lvl_q;
  logic                 found_q, clamp_q, neg_q;
  logic [LW-1:0]        mag_a_q;
  logic [PW-1:0]        mag_b_q, den_q;
  logic [NW-1:0]        prod_q;
  cell_ctl_t            ctl_q;
  logic signed [LW-1:0] pend_lvl_q, res_lvl_q;
  logic [CW-1:0]        pend_idx_q, res_idx_q, res_cnt_q;
  status_e              pend_st_q, res_st_q;
  logic                 res_valid_q;

  logic signed [PW-1:0] cell_pos [MAX_POINTS];
  logic signed [LW-1:0] cell_lvl [MAX_POINTS];
  logic signed [PW-1:0] rd_pos;
  logic signed [LW-1:0] rd_lvl;
  logic                 in_fire, scan_stop, div_start, div_done;
  logic [NW-1:0]        quot;
  logic signed [LW:0]   dy;
  logic [PW:0]          dx, den;

  // Cell chain
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    logic signed [PW-1:0] lp, rp;
    logic signed [LW-1:0] ll, rl;
    if (k == 0) begin : g_first
      assign lp = x_q;
      assign ll = v_q;
    end else begin : g_mid_l
      assign lp = cell_pos[k-1];
      assign ll = cell_lvl[k-1];
    end
    if (k == MAX_POINTS - 1) begin : g_last
      assign rp = cell_pos[k];
      assign rl = cell_lvl[k];
    end else begin : g_mid_r
      assign rp = cell_pos[k+1];
      assign rl = cell_lvl[k+1];
    end
    plt_cell #(.IDX(k), .PW(PW), .LW(LW)) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_q),
      .new_pos_i   (x_q),
      .new_lvl_i   (v_q),
      .left_pos_i  (lp),
      .left_lvl_i  (ll),
      .right_pos_i (rp),
      .right_lvl_i (rl),
      .pos_o       (cell_pos[k]),
      .lvl_o       (cell_lvl[k])
    );
  end

  // Scan read port and stop test
  assign rd_pos    = cell_pos[k_q[IW-1:0]];
  assign rd_lvl    = cell_lvl[k_q[IW-1:0]];
  assign scan_stop = (k_q == count_q) || !(rd_pos < x_q);

  // Interpolation operands
  assign dy  = {cur_lvl_q[LW-1], cur_lvl_q} - {prev_lvl_q[LW-1], prev_lvl_q};
  assign dx  = {x_q[PW-1], x_q} - {prev_pos_q[PW-1], prev_pos_q};
  assign den = {cur_pos_q[PW-1], cur_pos_q} - {prev_pos_q[PW-1], prev_pos_q};

  assign div_start = (state_q == S_DIVGO);

  plt_div #(.NW(NW), .DW(PW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // Configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= 1'b1;
    end else if (cfg_i.valid) begin
      clamp_q <= cfg_i.clamp_mode;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      ctl_q       <= '{op: CELL_HOLD, at: '0};
    end else begin
      // Cell op lasts one cycle; it is already HOLD when the decide step runs
      if (state_q != S_DECIDE) begin
        ctl_q.op <= CELL_HOLD;
      end
      // Result taken; the done step refills it itself
      if (res_valid_q && res_o.ready && state_q != S_DONE) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q      <= cmd_e'(in_i.cmd);
            x_q        <= in_i.pos_in;
            v_q        <= in_i.level_in;
            k_q        <= '0;
            pend_lvl_q <= '0;
            pend_idx_q <= '0;
            pend_st_q  <= ST_OK;
            if (cmd_e'(in_i.cmd) == CMD_CLEAR) begin
              count_q <= '0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_stop) begin
            cur_pos_q <= rd_pos;
            cur_lvl_q <= rd_lvl;
            found_q   <= (k_q != count_q) && (rd_pos == x_q);
            state_q   <= S_DECIDE;
          end else begin
            prev_pos_q <= rd_pos;
            prev_lvl_q <= rd_lvl;
            k_q        <= k_q + 1'b1;
          end
        end
        S_DECIDE: begin
          state_q <= S_DONE;
          case (cmd_q)
            CMD_INSERT: begin
              if (found_q) begin
                ctl_q      <= '{op: CELL_WRITE, at: AT_W'(k_q)};
                pend_idx_q <= k_q;
              end else if (count_q == FULL_CNT) begin
                pend_st_q <= ST_FULL;
              end else begin
                ctl_q      <= '{op: CELL_INS, at: AT_W'(k_q)};
                pend_idx_q <= k_q;
                count_q    <= count_q + 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (count_q == '0) begin
                pend_st_q <= ST_EMPTY;
              end else if (!found_q) begin
                pend_st_q <= ST_NOT_FOUND;
              end else begin
                ctl_q      <= '{op: CELL_DEL, at: AT_W'(k_q)};
                pend_idx_q <= k_q;
                count_q    <= count_q - 1'b1;
              end
            end
            default: begin
              // Evaluate
              if (count_q == '0) begin
                pend_st_q <= ST_EMPTY;
              end else if (k_q == count_q) begin
                // Above the last point
                pend_lvl_q <= clamp_q ? prev_lvl_q : '0;
              end else if (found_q) begin
                pend_lvl_q <= cur_lvl_q;
              end else if (k_q == '0) begin
                // Below the first point
                pend_lvl_q <= clamp_q ? cur_lvl_q : '0;
              end else begin
                neg_q   <= dy[LW];
                mag_a_q <= dy[LW] ? LW'(-dy) : dy[LW-1:0];
                mag_b_q <= dx[PW-1:0];
                den_q   <= den[PW-1:0];
                state_q <= S_MUL;
              end
            end
          endcase
        end
        S_MUL: begin
          prod_q  <= NW'(mag_a_q) * NW'(mag_b_q);
          state_q <= S_DIVGO;
        end
        S_DIVGO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            pend_lvl_q <= neg_q ? (prev_lvl_q - LW'(quot)) : (prev_lvl_q + LW'(quot));
            state_q    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_lvl_q   <= pend_lvl_q;
            res_idx_q   <= pend_idx_q;
            res_st_q    <= pend_st_q;
            res_cnt_q   <= count_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result beat
  assign res_o.valid        = res_valid_q;
  assign res_o.result_level = res_lvl_q;
  assign res_o.pt_idx       = IDX_OUT_W'(res_idx_q);
  assign res_o.status       = res_st_q;
  assign res_o.count_out    = CNT_OUT_W'(res_cnt_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("stored count above table depth");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside its wait state");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.cmd == CMD_CLEAR |=> count_q == '0)
    else $error("clear did not empty the table");

  a_cell_op_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.op != CELL_HOLD |-> $past(state_q) == S_DECIDE)
    else $error("cell chain moved outside the decide step");
`endif

endmodule
